// ===== design/hvd_pkg.sv =====
// Shared types and constants for the haversine distance pipeline.
// Used by every module of the block; depends on nothing.
package hvd_pkg;

	localparam int unsigned LON_W  = 29;
	localparam int unsigned LAT_W  = 28;
	localparam int unsigned DIST_W = 31;

	// Angles are degrees in Q24, trig values are Q30.
	localparam int unsigned ANG_W   = 35;
	localparam int unsigned TRIG_W  = 33;
	localparam int unsigned STEPS   = 28;
	localparam int unsigned ROOT_W  = 31;
	localparam int unsigned RAD_W   = 61;
	localparam int unsigned SQ_STEPS = 31;

	localparam logic signed [ANG_W-1:0] TURN_Q24    = 35'sd6039797760;
	localparam logic signed [ANG_W-1:0] HALF_Q24    = 35'sd3019898880;
	localparam logic signed [ANG_W-1:0] QUARTER_Q24 = 35'sd1509949440;
	localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic [31:0] KM_PER_DEG_Q24 = 32'd3731082605;

	localparam logic signed [TRIG_W-1:0] ATAN_Q24 [0:STEPS-1] = '{
		33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
		33'sd60000934, 33'sd30029717, 33'sd15018523, 33'sd7509720,
		33'sd3754917, 33'sd1877466, 33'sd938734, 33'sd469367,
		33'sd234684, 33'sd117342, 33'sd58671, 33'sd29335,
		33'sd14668, 33'sd7334, 33'sd3667, 33'sd1833,
		33'sd917, 33'sd458, 33'sd229, 33'sd115,
		33'sd57, 33'sd29, 33'sd14, 33'sd7
	};

	typedef struct packed {
		logic signed [LON_W-1:0] point_lon;
		logic signed [LAT_W-1:0] point_lat;
		logic                    last_point;
	} point_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              last_distance;
	} result_t;

	// Control that travels with each word down the pipeline.
	typedef struct packed {
		logic vld;
		logic last;
	} tag_t;

endpackage

// ===== design/hvd_sincos.sv =====
// Pipelined CORDIC rotation: sine and cosine of a Q24 degree angle.
// Uses hvd_pkg for widths, the arctangent table and the tag type.
module hvd_sincos (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  hvd_pkg::tag_t                         tag_i,
	input  logic signed [hvd_pkg::ANG_W-1:0]      ang,
	output hvd_pkg::tag_t                         tag_o,
	output logic signed [hvd_pkg::TRIG_W-1:0]     sin_o,
	output logic signed [hvd_pkg::TRIG_W-1:0]     cos_o
);
	localparam int unsigned N = hvd_pkg::STEPS;

	logic signed [hvd_pkg::TRIG_W-1:0] x_s [0:N];
	logic signed [hvd_pkg::TRIG_W-1:0] y_s [0:N];
	logic signed [hvd_pkg::TRIG_W-1:0] r_s [0:N];
	logic                              neg_s [0:N];
	hvd_pkg::tag_t                     tag_s [0:N];

	logic signed [hvd_pkg::ANG_W-1:0] wrap;
	logic signed [hvd_pkg::ANG_W-1:0] fold;
	logic                             fold_neg;

	// Wrap into [-180,180) and fold the outer half-plane onto the inner one.
	always_comb begin
		wrap = ang;
		if (ang >= hvd_pkg::HALF_Q24) begin
			wrap = ang - hvd_pkg::TURN_Q24;
		end else if (ang < -hvd_pkg::HALF_Q24) begin
			wrap = ang + hvd_pkg::TURN_Q24;
		end
		fold     = wrap;
		fold_neg = 1'b0;
		if (wrap > hvd_pkg::QUARTER_Q24) begin
			fold     = wrap - hvd_pkg::HALF_Q24;
			fold_neg = 1'b1;
		end else if (wrap < -hvd_pkg::QUARTER_Q24) begin
			fold     = wrap + hvd_pkg::HALF_Q24;
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (en) begin
			tag_s[0] <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= fold[hvd_pkg::TRIG_W-1:0];
			x_s[0]   <= hvd_pkg::INV_GAIN_Q30;
			y_s[0]   <= '0;
			neg_s[0] <= fold_neg;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else if (en) begin
				tag_s[i+1] <= tag_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i+1] <= neg_s[i];
				if (r_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					r_s[i+1] <= r_s[i] - hvd_pkg::ATAN_Q24[i];
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					r_s[i+1] <= r_s[i] + hvd_pkg::ATAN_Q24[i];
				end
			end
		end
	end

	assign tag_o = tag_s[N];
	assign sin_o = neg_s[N] ? -y_s[N] : y_s[N];
	assign cos_o = neg_s[N] ? -x_s[N] : x_s[N];

endmodule

// ===== design/hvd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, floor.
// Uses hvd_pkg for widths and the tag type.
module hvd_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  hvd_pkg::tag_t                     tag_i,
	input  logic [hvd_pkg::RAD_W-1:0]         rad,
	output hvd_pkg::tag_t                     tag_o,
	output logic [hvd_pkg::ROOT_W-1:0]        root
);
	localparam int unsigned N  = hvd_pkg::SQ_STEPS;
	localparam int unsigned RW = hvd_pkg::RAD_W + 1;

	logic [hvd_pkg::RAD_W-1:0] v_s [0:N];
	logic [RW-1:0]             r_s [0:N];
	hvd_pkg::tag_t             tag_s [0:N];

	assign v_s[0]   = rad;
	assign r_s[0]   = '0;
	assign tag_s[0] = tag_i;

	for (genvar k = 0; k < N; k++) begin : g_bit
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - k));
		logic [RW:0] trial;

		assign trial = {1'b0, r_s[k]} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, v_s[k]} >= trial) begin
					v_s[k+1] <= v_s[k] - trial[hvd_pkg::RAD_W-1:0];
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign tag_o = tag_s[N];
	assign root  = r_s[N][hvd_pkg::ROOT_W-1:0];

endmodule

// ===== design/hvd_atan2.sv =====
// Pipelined CORDIC vectoring: half central angle atan2(y, x) in Q24 degrees,
// clamped to [0, 90] in a final stage. Uses hvd_pkg.
module hvd_atan2 (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  hvd_pkg::tag_t                     tag_i,
	input  logic [hvd_pkg::ROOT_W-1:0]        y_in,
	input  logic [hvd_pkg::ROOT_W-1:0]        x_in,
	output hvd_pkg::tag_t                     tag_o,
	output logic [30:0]                       half_ang
);
	localparam int unsigned N  = hvd_pkg::STEPS;
	localparam int unsigned VW = 34;

	logic signed [VW-1:0]              x_s [0:N];
	logic signed [VW-1:0]              y_s [0:N];
	logic signed [hvd_pkg::TRIG_W-1:0] z_s [0:N];
	hvd_pkg::tag_t                     tag_s [0:N];
	hvd_pkg::tag_t                     tag_q;
	logic [30:0]                       half_q;

	assign x_s[0]   = $signed({3'b000, x_in});
	assign y_s[0]   = $signed({3'b000, y_in});
	assign z_s[0]   = '0;
	assign tag_s[0] = tag_i;

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i+1] <= '0;
			end else if (en) begin
				tag_s[i+1] <= tag_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + hvd_pkg::ATAN_Q24[i];
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - hvd_pkg::ATAN_Q24[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_s[N] < 0) begin
				half_q <= '0;
			end else if (z_s[N] > hvd_pkg::QUARTER_Q24[hvd_pkg::TRIG_W-1:0]) begin
				half_q <= hvd_pkg::QUARTER_Q24[30:0];
			end else begin
				half_q <= z_s[N][30:0];
			end
		end
	end

	assign tag_o    = tag_q;
	assign half_ang = half_q;

endmodule

// ===== design/haversine_distance_stream_top.sv =====
// Haversine great-circle distance stream: top level with register port,
// product stages, scaling and output buffer. Uses hvd_pkg and all hvd_ modules.
// Throughput: one point per cycle while point_stall is low; every CORDIC and root step is its own stage.
// A two-entry output buffer lets the pipeline run while one result waits.
// Reset clears both query registers to zero and empties the pipeline.
module haversine_distance_stream_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_stall,
	input  hvd_pkg::point_t      point,
	output logic                 result_valid,
	input  logic                 result_stall,
	output hvd_pkg::result_t     result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	localparam logic REG_LON = 1'b0;
	localparam logic REG_LAT = 1'b1;

	logic signed [hvd_pkg::LON_W-1:0] query_lon_q;
	logic signed [hvd_pkg::LAT_W-1:0] query_lat_q;

	logic en;

	// Register port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_lon_q <= '0;
			query_lat_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_LON: query_lon_q <= pwdata[hvd_pkg::LON_W-1:0];
				REG_LAT: query_lat_q <= pwdata[hvd_pkg::LAT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LON: prdata = {{(32-hvd_pkg::LON_W){1'b0}}, query_lon_q};
			REG_LAT: prdata = {{(32-hvd_pkg::LAT_W){1'b0}}, query_lat_q};
			default: prdata = '0;
		endcase
	end

	// Stage 1: capture the point together with the query.
	hvd_pkg::tag_t                    tag_s1;
	logic signed [hvd_pkg::LON_W-1:0] lon2_s1, lon1_s1;
	logic signed [hvd_pkg::LAT_W-1:0] lat2_s1, lat1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.vld  <= point_valid;
			tag_s1.last <= point.last_point;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon2_s1 <= point.point_lon;
			lat2_s1 <= point.point_lat;
			lon1_s1 <= query_lon_q;
			lat1_s1 <= query_lat_q;
		end
	end

	logic signed [hvd_pkg::ANG_W-1:0] dlat_ang, dlon_ang, lat1_ang, lat2_ang;

	// Half differences are the Q20 difference times 8; latitudes times 16.
	assign dlat_ang = (hvd_pkg::ANG_W'(lat2_s1) - hvd_pkg::ANG_W'(lat1_s1)) <<< 3;
	assign dlon_ang = (hvd_pkg::ANG_W'(lon2_s1) - hvd_pkg::ANG_W'(lon1_s1)) <<< 3;
	assign lat1_ang = hvd_pkg::ANG_W'(lat1_s1) <<< 4;
	assign lat2_ang = hvd_pkg::ANG_W'(lat2_s1) <<< 4;

	hvd_pkg::tag_t                     tag_trig, tag_u1, tag_u2, tag_u3;
	logic signed [hvd_pkg::TRIG_W-1:0] s_lat, s_lon, c1, c2;

	hvd_sincos u_dlat (.clk, .arst_n, .en, .tag_i(tag_s1), .ang(dlat_ang),
		.tag_o(tag_trig), .sin_o(s_lat), .cos_o());
	hvd_sincos u_dlon (.clk, .arst_n, .en, .tag_i(tag_s1), .ang(dlon_ang),
		.tag_o(tag_u1), .sin_o(s_lon), .cos_o());
	hvd_sincos u_lat1 (.clk, .arst_n, .en, .tag_i(tag_s1), .ang(lat1_ang),
		.tag_o(tag_u2), .sin_o(), .cos_o(c1));
	hvd_sincos u_lat2 (.clk, .arst_n, .en, .tag_i(tag_s1), .ang(lat2_ang),
		.tag_o(tag_u3), .sin_o(), .cos_o(c2));

	// Q30 product on magnitudes, rounded half up, sign restored.
	function automatic logic signed [35:0] mul_q30(input logic signed [35:0] a,
			input logic signed [35:0] b);
		logic [35:0] ma, mb;
		logic [63:0] p;
		logic [33:0] r;
		ma = a[35] ? -a : a;
		mb = b[35] ? -b : b;
		p  = ma[31:0] * mb[31:0];
		r  = 34'((p + 64'd536870912) >> 30);
		return (a[35] != b[35]) ? -$signed({2'b00, r}) : $signed({2'b00, r});
	endfunction

	// Stage 2: the three first products.
	hvd_pkg::tag_t      tag_s2;
	logic signed [35:0] lat_sq_s2, lon_sq_s2, cc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_trig;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_sq_s2 <= mul_q30(36'(s_lat), 36'(s_lat));
			lon_sq_s2 <= mul_q30(36'(s_lon), 36'(s_lon));
			cc_s2     <= mul_q30(36'(c1), 36'(c2));
		end
	end

	// Stage 3: cross term.
	hvd_pkg::tag_t      tag_s3;
	logic signed [35:0] lat_sq_s3, cross_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_sq_s3 <= lat_sq_s2;
			cross_s3  <= mul_q30(cc_s2, lon_sq_s2);
		end
	end

	// Stage 4: sum, clamp to [0, 1], and form both root radicands.
	hvd_pkg::tag_t             tag_s4;
	logic [hvd_pkg::RAD_W-1:0] rad_sin_s4, rad_cos_s4;
	logic signed [36:0]        a_sum;
	logic [30:0]               a_clip;

	always_comb begin
		a_sum = 37'(lat_sq_s3) + 37'(cross_s3);
		if (a_sum < 0) begin
			a_clip = '0;
		end else if (a_sum > $signed({6'd0, hvd_pkg::ONE_Q30})) begin
			a_clip = hvd_pkg::ONE_Q30;
		end else begin
			a_clip = a_sum[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else if (en) begin
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_sin_s4 <= {a_clip, 30'd0};
			rad_cos_s4 <= {hvd_pkg::ONE_Q30 - a_clip, 30'd0};
		end
	end

	hvd_pkg::tag_t              tag_root, tag_root_c;
	logic [hvd_pkg::ROOT_W-1:0] root_s, root_c;

	hvd_isqrt u_sq_sin (.clk, .arst_n, .en, .tag_i(tag_s4), .rad(rad_sin_s4),
		.tag_o(tag_root), .root(root_s));
	hvd_isqrt u_sq_cos (.clk, .arst_n, .en, .tag_i(tag_s4), .rad(rad_cos_s4),
		.tag_o(tag_root_c), .root(root_c));

	hvd_pkg::tag_t tag_ang;
	logic [30:0]   half_ang;

	hvd_atan2 u_atan2 (.clk, .arst_n, .en, .tag_i(tag_root), .y_in(root_s),
		.x_in(root_c), .tag_o(tag_ang), .half_ang(half_ang));

	// Stage 5: scale to km.
	hvd_pkg::tag_t tag_s5;
	logic [62:0]   prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
		end else if (en) begin
			tag_s5 <= tag_ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= half_ang * hvd_pkg::KM_PER_DEG_Q24;
		end
	end

	logic [31:0]      dist_round;
	hvd_pkg::result_t fin_word;
	logic             push;

	assign dist_round = 32'((64'(prod_s5) + 64'h8000_0000) >> 32);
	assign fin_word.distance      = dist_round[31] ? '1 : dist_round[30:0];
	assign fin_word.last_distance = tag_s5.last;

	// Output register plus skid entry; the pipeline holds only when both are full.
	logic             out_vld_q, skid_vld_q;
	hvd_pkg::result_t out_q, skid_q;
	logic             pop;

	assign en   = !skid_vld_q;
	assign push = en && tag_s5.vld;
	assign pop  = out_vld_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop || !out_vld_q) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_vld_q) begin
			out_q <= skid_vld_q ? skid_q : fin_word;
		end else if (push) begin
			skid_q <= fin_word;
		end
	end

	assign point_stall  = skid_vld_q;
	assign result_valid = out_vld_q;
	assign result       = out_q;

	// The skid entry is only ever occupied behind a waiting output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry holds a word while output is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(result_valid && result_stall))
		else $error("skid entry filled without a stalled output");

	a_sincos_align: assert property (@(posedge clk) disable iff (!arst_n)
		tag_trig.vld == tag_u1.vld && tag_u2.vld == tag_u3.vld && tag_trig.vld == tag_u2.vld)
		else $error("sine and cosine lanes out of step");

	a_root_align: assert property (@(posedge clk) disable iff (!arst_n)
		tag_root.vld == tag_root_c.vld)
		else $error("root lanes out of step");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for haversine_distance_stream_top: random points and query settings,
// checked against an in-bench fixed-point haversine calculation. Depends on hvd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LON_SPAN = 377487360;
	localparam int LAT_SPAN = 188743680;
	localparam longint DEG = 64'sd1 << 24;
	localparam longint TURN = 360 * DEG;
	localparam longint HALF = 180 * DEG;
	localparam longint QUARTER = 90 * DEG;
	localparam longint ONE30 = 64'sd1 << 30;
	localparam longint unsigned KM_SCALE =
		(2 * 6371 * 64'd13493037705 + 180 * 128) / (180 * 256);
	localparam longint ARC [0:27] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
		117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
		115, 57, 29, 14, 7
	};

	logic clk = 0;
	logic arst_n = 0;
	logic point_valid = 0;
	logic point_stall;
	hvd_pkg::point_t point = '0;
	logic result_valid;
	logic result_stall = 0;
	hvd_pkg::result_t result;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	haversine_distance_stream_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	logic signed [hvd_pkg::LON_W-1:0] query_lon = '0;
	logic signed [hvd_pkg::LAT_W-1:0] query_lat = '0;
	hvd_pkg::point_t pending_points [$];
	hvd_pkg::result_t expected_dists [$];
	bit calm = 0;
	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int stall_left = 0;

	function automatic longint mul30(longint a, longint b);
		longint unsigned ma, mb, p;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = (ma * mb + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	task automatic sin_cos(input longint ang, output longint s, output longint c);
		longint r, x, y, dx, dy;
		bit neg;
		r = ang % TURN;
		neg = 0;
		x = 652032874;
		y = 0;
		if (r >= HALF) r -= TURN;
		if (r < -HALF) r += TURN;
		if (r > QUARTER) begin
			r -= HALF;
			neg = 1;
		end else if (r < -QUARTER) begin
			r += HALF;
			neg = 1;
		end
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (r >= 0) begin
				x -= dx; y += dy; r -= ARC[i];
			end else begin
				x += dx; y -= dy; r += ARC[i];
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endtask

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint half_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < 28; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ARC[i];
			end else begin
				x -= dx; y += dy; z -= ARC[i];
			end
		end
		if (z < 0) z = 0;
		if (z > QUARTER) z = QUARTER;
		return z;
	endfunction

	task automatic great_circle(input hvd_pkg::point_t p, output hvd_pkg::result_t r);
		longint lon1, lat1, lon2, lat2, s_lat, s_lon, c1, c2, unused, a, h;
		longint unsigned d;
		lon1 = longint'(query_lon);
		lat1 = longint'(query_lat);
		lon2 = longint'(p.point_lon);
		lat2 = longint'(p.point_lat);
		sin_cos((lat2 - lat1) * 8, s_lat, unused);
		sin_cos((lon2 - lon1) * 8, s_lon, unused);
		sin_cos(lat1 * 16, unused, c1);
		sin_cos(lat2 * 16, unused, c2);
		a = mul30(s_lat, s_lat) + mul30(mul30(c1, c2), mul30(s_lon, s_lon));
		if (a < 0) a = 0;
		if (a > ONE30) a = ONE30;
		h = half_angle(longint'(root64(a << 30)), longint'(root64((ONE30 - a) << 30)));
		d = (longint'(h) * KM_SCALE + (64'd1 << 31)) >> 32;
		if (d > 64'h7FFFFFFF) d = 64'h7FFFFFFF;
		r.distance = d[hvd_pkg::DIST_W-1:0];
		r.last_distance = p.last_point;
	endtask

	// Sender: holds a stalled word, otherwise idles in bursts or offers the next point.
	always @(posedge clk or negedge arst_n) begin
		hvd_pkg::result_t r;
		if (!arst_n) begin
			point_valid <= 0;
		end else begin
			if (point_valid && !point_stall) begin
				great_circle(point, r);
				expected_dists.push_back(r);
				void'(pending_points.pop_front());
			end
			if (point_valid && point_stall) begin
			end else if (send_gap > 0) begin
				send_gap--;
				point_valid <= 0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 10);
				point_valid <= 0;
			end else if (pending_points.size() > 0) begin
				point_valid <= 1;
				point <= pending_points[0];
			end else begin
				point_valid <= 0;
			end
		end
	end

	// Receiver: random stall bursts and comparison against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		hvd_pkg::result_t e;
		if (!arst_n) begin
			result_stall <= 0;
		end else begin
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("** haversine_distance_stream_top: FAILED **");
				$finish;
			end
			if (result_valid && !result_stall) begin
				if (expected_dists.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word: distance %h last %b",
							result.distance, result.last_distance);
				end else begin
					e = expected_dists.pop_front();
					if (e !== result) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected distance %h last %b, got %h last %b",
								e.distance, e.last_distance, result.distance,
								result.last_distance);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 10);
				result_stall <= 1;
			end else begin
				result_stall <= 0;
			end
		end
	end

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == 3'd0) query_lon = data[hvd_pkg::LON_W-1:0];
		if (addr == 3'd4) query_lat = data[hvd_pkg::LAT_W-1:0];
	endtask

	task automatic add_point(input int lon, input int lat, input bit last);
		hvd_pkg::point_t p;
		p.point_lon = hvd_pkg::LON_W'(lon);
		p.point_lat = hvd_pkg::LAT_W'(lat);
		p.last_point = last;
		pending_points.push_back(p);
	endtask

	function automatic int rand_lon();
		return ($urandom_range(0, 3) == 0) ? int'($urandom)
			: int'($urandom_range(0, LON_SPAN)) - LON_SPAN / 2;
	endfunction

	function automatic int rand_lat();
		return ($urandom_range(0, 3) == 0) ? int'($urandom)
			: int'($urandom_range(0, LAT_SPAN)) - LAT_SPAN / 2;
	endfunction

	task automatic drain();
		do @(negedge clk);
		while (pending_points.size() != 0 || expected_dists.size() != 0);
		repeat (5) @(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed points against the reset query: extremes, poles, antipodes, raw patterns.
		add_point(0, 0, 0);
		add_point(LON_SPAN / 2, 0, 1);
		add_point(-LON_SPAN / 2, 0, 0);
		add_point(0, LAT_SPAN / 2, 0);
		add_point(0, -LAT_SPAN / 2, 1);
		add_point(LON_SPAN / 2, LAT_SPAN / 2, 0);
		add_point(-LON_SPAN / 2, -LAT_SPAN / 2, 0);
		add_point(LON_SPAN / 4, LAT_SPAN / 4, 1);
		add_point(1, 1, 0);
		add_point(-1, -1, 0);
		add_point(32'h0FFFFFFF, 32'h07FFFFFF, 1);
		add_point(32'h10000000, 32'h08000000, 0);
		add_point(32'h1FFFFFFF, 32'h0FFFFFFF, 1);
		drain();
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(3'd0, LON_SPAN / 2);
					write_reg(3'd4, LAT_SPAN / 2);
				end
				1: begin
					write_reg(3'd0, -LON_SPAN / 2);
					write_reg(3'd4, -LAT_SPAN / 2);
				end
				2: begin
					write_reg(3'd0, 32'hFFFFFFFF);
					write_reg(3'd4, 32'h08000000);
				end
				default: begin
					write_reg(3'd0, rand_lon());
					write_reg(3'd4, rand_lat());
				end
			endcase
			@(negedge clk);
			if (ph == 0) begin
				// Antipode and self distance of the new query point.
				add_point(-LON_SPAN / 2, -LAT_SPAN / 2, 0);
				add_point(LON_SPAN / 2, LAT_SPAN / 2, 1);
				add_point(0, -LAT_SPAN / 2, 0);
			end
			if (ph == 6) calm = 1;
			for (int i = 0; i < 115; i++)
				add_point(rand_lon(), rand_lat(), 1'($urandom_range(0, 1)));
			drain();
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_dists.size() == 0) begin
			$display("** haversine_distance_stream_top: PASSED **");
		end else begin
			$display("** haversine_distance_stream_top: FAILED **");
		end
		$finish;
	end

endmodule
